// ===== rtl/core/coeff_compress_bit_packer_core_macros.svh =====
// Assertion macros for the coefficient compressor and bit packer.
`ifndef COEFF_COMPRESS_BIT_PACKER_CORE_MACROS_SVH
`define COEFF_COMPRESS_BIT_PACKER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define CCBP_ASSERT(name, ck, rs, prop, msg) \
  name: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
// Condition must never be seen outside reset.
`define CCBP_ASSERT_NEVER(name, ck, rs, cond, msg) \
  name: assert property (@(posedge ck) disable iff (rs) !(cond)) else $error(msg);
`else
`define CCBP_ASSERT(name, ck, rs, prop, msg)
`define CCBP_ASSERT_NEVER(name, ck, rs, cond, msg)
`endif

`endif

// ===== rtl/core/ccbp_pkg.sv =====
package ccbp_pkg;

  localparam int unsigned DEF_MODULUS_Q  = 7681;
  localparam int unsigned DEF_COEFF_BITS = 13;

  localparam int unsigned CFG_W  = 4;
  localparam int unsigned D_MIN  = 8;
  localparam int unsigned D_MAX  = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(11);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PEND_W = 7;
  localparam int unsigned PCNT_W = 3;

  // Depth of the byte queue in front of the output; a power of two.
  localparam int unsigned OUT_DEPTH = 4;

  // Codes below the supported range act as the narrowest width, codes above as the widest.
  function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] raw);
    logic [CFG_W-1:0] d;
    priority if (raw < CFG_W'(D_MIN)) begin
      d = CFG_W'(D_MIN);
    end else if (raw > CFG_W'(D_MAX)) begin
      d = CFG_W'(D_MAX);
    end else begin
      d = raw;
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/coeff_compress_bit_packer_core.sv =====
// Coefficient compressor and LSB-first bit packer.
// Input channel: in_valid / in_stall with coeff, one coefficient per item. The coefficient
// is reduced modulo MODULUS_Q, compressed to d bits with rounding and packed into a
// byte stream, least significant bit first.
// Output channel: out_valid / out_stall with packed_byte and last_of_run, one byte per
// item; each coefficient gives one or two bytes and last_of_run marks its final byte.
// Config channel: cfg_valid / cfg_ready with compress_bits (d, 8..11, reset 11); cfg_ready
// is always high. Write it only while no coefficient is in flight.
// Pipeline: input register, two reduction stages, three compression stages, then the
// byte queue in front of the output.
// Throughput: a new coefficient can enter every cycle while in_stall is low; the single
// byte-wide output port sets the sustained rate, as each coefficient gives one or two bytes.
// Reset clears the leftover bits, empties the pipeline and the byte queue, and sets d to 11.
// When the receiver stalls the byte queue fills, the pipeline holds and in_stall rises
// once no stage can take a new item; nothing is lost or reordered.
`include "coeff_compress_bit_packer_core_macros.svh"

module coeff_compress_bit_packer_core import ccbp_pkg::*; #(
  parameter int unsigned MODULUS_Q  = DEF_MODULUS_Q,
  parameter int unsigned COEFF_BITS = DEF_COEFF_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      compress_bits,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COEFF_BITS-1:0] coeff,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BYTE_W-1:0]     packed_byte,
  output logic                  last_of_run
);

  localparam int unsigned XW    = $clog2(MODULUS_Q);
  localparam int unsigned RW    = COEFF_BITS + 1;
  localparam int unsigned K1    = COEFF_BITS;
  localparam int unsigned M1W   = K1 - 7;
  localparam int unsigned M1    = (2 ** K1) / MODULUS_Q;
  localparam int unsigned P1W   = COEFF_BITS + M1W;
  localparam int unsigned NUM_W = XW + D_MAX + 1;
  localparam int unsigned K2    = NUM_W;
  localparam int unsigned M2W   = K2 - 7;
  localparam int unsigned M2    = (2 ** K2) / MODULUS_Q;
  localparam int unsigned P2W   = NUM_W + M2W;
  localparam int unsigned TW    = D_MAX;
  localparam int unsigned ACC_W = TW + PEND_W;
  localparam int unsigned TOT_W = $clog2(PEND_W + D_MAX + 1);
  localparam int unsigned IW    = $clog2(OUT_DEPTH);
  localparam int unsigned QCW   = $clog2(OUT_DEPTH + 1);

  localparam logic [M1W-1:0]   M1_L   = M1W'(M1);
  localparam logic [M2W-1:0]   M2_L   = M2W'(M2);
  localparam logic [RW-1:0]    Q_R    = RW'(MODULUS_Q);
  localparam logic [NUM_W-1:0] Q_N    = NUM_W'(MODULUS_Q);
  localparam logic [NUM_W-1:0] HALF_N = NUM_W'(MODULUS_Q / 2);

  // Configuration
  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] d_eff;

  // Pipeline stages
  logic                  v_a, v_b, v_c, v_d, v_e, v_f;
  logic                  rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_f;
  logic [COEFF_BITS-1:0] coeff_a, coeff_b;
  logic [P1W-1:0]        prod1_b;
  logic [XW-1:0]         x_c;
  logic [NUM_W-1:0]      num_d, num_e;
  logic [P2W-1:0]        prod2_e;
  logic [TW-1:0]         t_f;

  logic [P1W-1:0]   prod1_next;
  logic [M1W-1:0]   q1;
  logic [RW-1:0]    qq1, r0, r1;
  logic [NUM_W-1:0] num_next;
  logic [P2W-1:0]   prod2_next;
  logic [M2W-1:0]   q2, q2c;
  logic [NUM_W-1:0] qq2, rem2;
  logic [TW-1:0]    t_mask, t_next;

  // Packer
  logic [PEND_W-1:0] pend_bits, pend_bits_next, pend_mask;
  logic [PCNT_W-1:0] pend_cnt, pend_cnt_next;
  logic [ACC_W-1:0]  acc, acc_rest;
  logic [TOT_W-1:0]  total;
  logic              two;
  logic              pack_ready, pack_fire;

  // Byte queue
  logic [BYTE_W-1:0] q_byte [OUT_DEPTH];
  logic              q_last [OUT_DEPTH];
  logic [IW-1:0]     head, tail, tail_p1;
  logic [QCW-1:0]    q_count, q_count_next;
  logic [QCW-1:0]    push_n;
  logic              pop;

  assign cfg_ready = 1'b1;
  assign d_eff     = clamp_width(width_cfg);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_cfg <= compress_bits;
    end
  end

  // A stage takes a new item when it is empty or its item moves on.
  assign rdy_f    = !v_f || pack_ready;
  assign rdy_e    = !v_e || rdy_f;
  assign rdy_d    = !v_d || rdy_e;
  assign rdy_c    = !v_c || rdy_d;
  assign rdy_b    = !v_b || rdy_c;
  assign rdy_a    = !v_a || rdy_b;
  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_c <= 1'b0;
      v_d <= 1'b0;
      v_e <= 1'b0;
      v_f <= 1'b0;
    end else begin
      if (rdy_a) v_a <= in_valid;
      if (rdy_b) v_b <= v_a;
      if (rdy_c) v_c <= v_b;
      if (rdy_d) v_d <= v_c;
      if (rdy_e) v_e <= v_d;
      if (rdy_f) v_f <= v_e;
    end
  end

  // Reduction: Barrett estimate of the quotient, then one correcting subtract.
  assign prod1_next = P1W'(coeff_a) * P1W'(M1_L);
  assign q1         = prod1_b[P1W-1:K1];
  assign qq1        = RW'(RW'(q1) * Q_R);
  assign r0         = RW'(coeff_b) - qq1;
  assign r1         = (r0 >= Q_R) ? (r0 - Q_R) : r0;

  // Compression: round(x * 2^d / Q) by the same estimate-and-correct scheme.
  assign num_next   = (NUM_W'(x_c) << d_eff) + HALF_N;
  assign prod2_next = P2W'(num_d) * P2W'(M2_L);
  assign q2         = prod2_e[P2W-1:K2];
  assign qq2        = NUM_W'(NUM_W'(q2) * Q_N);
  assign rem2       = num_e - qq2;
  assign q2c        = (rem2 >= Q_N) ? (q2 + M2W'(1)) : q2;
  assign t_mask     = ~({TW{1'b1}} << d_eff);
  assign t_next     = TW'(q2c) & t_mask;

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      coeff_a <= coeff;
    end
    if (v_a && rdy_b) begin
      coeff_b <= coeff_a;
      prod1_b <= prod1_next;
    end
    if (v_b && rdy_c) begin
      x_c <= XW'(r1);
    end
    if (v_c && rdy_d) begin
      num_d <= num_next;
    end
    if (v_d && rdy_e) begin
      num_e   <= num_d;
      prod2_e <= prod2_next;
    end
    if (v_e && rdy_f) begin
      t_f <= t_next;
    end
  end

  // Append the compressed value above the leftover bits and cut off one or two bytes.
  assign acc            = ACC_W'(pend_bits) | (ACC_W'(t_f) << pend_cnt);
  assign total          = TOT_W'(pend_cnt) + TOT_W'(d_eff);
  assign two            = total >= TOT_W'(2 * BYTE_W);
  assign pend_cnt_next  = two ? PCNT_W'(total - TOT_W'(2 * BYTE_W))
                              : PCNT_W'(total - TOT_W'(BYTE_W));
  assign acc_rest       = two ? (acc >> (2 * BYTE_W)) : (acc >> BYTE_W);
  assign pend_mask      = ~({PEND_W{1'b1}} << pend_cnt_next);
  assign pend_bits_next = PEND_W'(acc_rest) & pend_mask;

  // Room for two bytes is needed before an item may be packed.
  assign pack_ready = q_count <= QCW'(OUT_DEPTH - 2);
  assign pack_fire  = v_f && pack_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= '0;
      pend_cnt  <= '0;
    end else if (pack_fire) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

  assign out_valid    = q_count != '0;
  assign packed_byte  = q_byte[head];
  assign last_of_run  = q_last[head];
  assign pop          = out_valid && !out_stall;
  assign tail_p1      = tail + IW'(1);
  assign push_n       = pack_fire ? (two ? QCW'(2) : QCW'(1)) : '0;
  assign q_count_next = q_count + push_n - QCW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      tail    <= '0;
      q_count <= '0;
    end else begin
      q_count <= q_count_next;
      tail    <= tail + IW'(push_n);
      if (pop) head <= head + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pack_fire) begin
      q_byte[tail] <= acc[BYTE_W-1:0];
      q_last[tail] <= !two;
      if (two) begin
        q_byte[tail_p1] <= acc[2*BYTE_W-1:BYTE_W];
        q_last[tail_p1] <= 1'b1;
      end
    end
  end

  `CCBP_ASSERT_NEVER(a_queue_bound, clk, rst, q_count > QCW'(OUT_DEPTH), "byte queue overrun")
  `CCBP_ASSERT(a_pack_hold, clk, rst, v_f && !pack_ready |=> v_f && $stable(t_f), "blocked item lost")
  `CCBP_ASSERT(a_two_byte_rest, clk, rst, pack_fire && two |=> pend_cnt <= PCNT_W'(2), "leftover too wide")
  `CCBP_ASSERT(a_pop_count, clk, rst, pop && !pack_fire |=> q_count == $past(q_count) - QCW'(1), "queue count slip")
  `CCBP_ASSERT(a_accept_lands, clk, rst, in_valid && !in_stall |=> v_a, "accepted item dropped")

endmodule
